[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file lkv_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lkv_pkg.sv]
// ---------------------------------------------------------------------------
// lkv_pkg
// Widths, step codes and controller/datapath bundles of the LRU cache.
// ---------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_SPACE_DEF = 128;
  localparam int CAP_W         = 8;
  localparam int KEY_W         = 8;
  localparam int VAL_W         = 32;
  localparam int EVK_W         = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd2;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // datapath steps
  localparam logic [2:0] STEP_NONE  = 3'd0;
  localparam logic [2:0] STEP_CLR   = 3'd1;
  localparam logic [2:0] STEP_HIT   = 3'd2;
  localparam logic [2:0] STEP_INS   = 3'd3;
  localparam logic [2:0] STEP_MV1   = 3'd4;
  localparam logic [2:0] STEP_MV2   = 3'd5;
  localparam logic [2:0] STEP_LINK  = 3'd6;
  localparam logic [2:0] STEP_EVICT = 3'd7;

  typedef struct packed {
    logic       ld_in;
    logic       rd_en;
    logic       rd_tail;
    logic [2:0] step;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic in_key_ok;
    logic kind;
    logic found;
    logic skip_move;
    logic list_empty;
    logic over;
    logic out_free;
    logic clr_last;
  } status_t;

endpackage

[design/lkv_if.sv]
// ---------------------------------------------------------------------------
// lkv_if
// Request and response channels of the LRU cache.
// ---------------------------------------------------------------------------
interface lkv_req_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        key;
  logic signed [31:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink (input valid, kind, key, value, output ready);
endinterface

interface lkv_rsp_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               found;
  logic signed [31:0] read_value;
  logic               evicted;
  logic [6:0]         evicted_key;

  modport source (output valid, accepted, found, read_value, evicted, evicted_key,
                  input ready);
  modport sink (input valid, accepted, found, read_value, evicted, evicted_key,
                output ready);
endinterface

[design/lru_key_value_cache.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache
// Key-value cache over a direct slot table with least-recently-used eviction.
//
//   channel  dir  word                                       handshake
//   req      in   kind, key, value                           valid/ready
//   rsp      out  accepted, found, read_value, evicted,      valid/ready
//                 evicted_key
//   cfg      in   capacity                                   cfg_write_en
//
// One word at a time. A rejected key goes straight to the response; others read
// their slot first. A hit not at the front is relinked at the front; a put of a
// new key is pushed at the front and evicts the tail when the count then exceeds
// the capacity. Each link step is one access to the single-port prev/next slot
// memories. After reset a sweep over all KEY_SPACE slots clears the valid marks;
// req.ready stays low meanwhile. The response register lets the next word be
// taken while a response waits on rsp.ready; that word then waits in S_DONE.
// ---------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int KEY_SPACE = KEY_SPACE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [CAP_W-1:0] cfg_write_data,
  lkv_req_if.sink          req,
  lkv_rsp_if.source        rsp
);

  cmd_t    cmd;
  status_t status;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .KEY_SPACE (KEY_SPACE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_kind       (req.kind),
    .req_key        (req.key),
    .req_value      (req.value),
    .rsp_ready      (rsp.ready),
    .cmd            (cmd),
    .status         (status),
    .rsp_valid      (rsp.valid),
    .accepted       (rsp.accepted),
    .found          (rsp.found),
    .read_value     (rsp.read_value),
    .evicted        (rsp.evicted),
    .evicted_key    (rsp.evicted_key)
  );

endmodule

[design/lkv_ctrl.sv]
// ---------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: runs the reset sweep, then steps one word through lookup, relink and eviction.
// ---------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_MV1   = 4'd4;
  localparam logic [3:0] S_MV2   = 4'd5;
  localparam logic [3:0] S_MV3   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_EVCHK = 4'd8;
  localparam logic [3:0] S_EVDO  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_INIT: begin
        cmd.step = STEP_CLR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = status.in_key_ok ? S_LOOK : S_DONE;
        end
      end
      S_LOOK: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (!status.found && status.kind == KIND_PUT) begin
          cmd.step   = STEP_INS;
          state_next = status.list_empty ? S_EVCHK : S_PUSH;
        end else begin
          cmd.step   = STEP_HIT;
          state_next = (status.found && !status.skip_move) ? S_MV1 : S_DONE;
        end
      end
      S_MV1: begin
        cmd.step   = STEP_MV1;
        state_next = S_MV2;
      end
      S_MV2: begin
        cmd.step   = STEP_MV2;
        state_next = S_MV3;
      end
      S_MV3: begin
        cmd.step   = STEP_LINK;
        state_next = S_DONE;
      end
      S_PUSH: begin
        cmd.step   = STEP_LINK;
        state_next = S_EVCHK;
      end
      S_EVCHK: begin
        if (status.over) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_tail = 1'b1;
          state_next  = S_EVDO;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EVDO: begin
        cmd.step   = STEP_EVICT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

[design/lkv_datapath.sv]
// ---------------------------------------------------------------------------
// lkv_datapath
// Slot memories, recency list pointers and the result register.
// ---------------------------------------------------------------------------
module lkv_datapath import lkv_pkg::*; #(
  parameter int KEY_SPACE = KEY_SPACE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [CAP_W-1:0]        cfg_write_data,
  input  logic                    req_kind,
  input  logic [KEY_W-1:0]        req_key,
  input  logic signed [VAL_W-1:0] req_value,
  input  logic                    rsp_ready,
  input  cmd_t                    cmd,
  output status_t                 status,
  output logic                    rsp_valid,
  output logic                    accepted,
  output logic                    found,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted,
  output logic [EVK_W-1:0]        evicted_key
);

  localparam int IDX_W = $clog2(KEY_SPACE);
  localparam int CNT_W = $clog2(KEY_SPACE + 1);
  localparam int LNK_W = IDX_W + 1;  // msb: null flag

  // slot memories
  logic             valid_mem [KEY_SPACE];
  logic [VAL_W-1:0] value_mem [KEY_SPACE];
  logic [LNK_W-1:0] prev_mem  [KEY_SPACE];
  logic [LNK_W-1:0] next_mem  [KEY_SPACE];

  logic [CAP_W-1:0] capacity;
  logic             kind_r;
  logic [IDX_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] clr_idx;

  logic             valid_q;
  logic [VAL_W-1:0] value_q;
  logic [LNK_W-1:0] prev_q;
  logic [LNK_W-1:0] next_q;

  logic             res_accepted;
  logic             res_found;
  logic [VAL_W-1:0] res_rv;
  logic             res_ev;
  logic [EVK_W-1:0] res_evk;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] p_idx;
  logic [IDX_W-1:0] n_idx;
  logic             in_key_ok;

  logic             vld_we;
  logic [IDX_W-1:0] vld_addr;
  logic             vld_data;
  logic             val_we;
  logic [IDX_W-1:0] val_addr;
  logic             prv_we;
  logic [IDX_W-1:0] prv_addr;
  logic [LNK_W-1:0] prv_data;
  logic             nxt_we;
  logic [IDX_W-1:0] nxt_addr;
  logic [LNK_W-1:0] nxt_data;

  assign rd_addr   = cmd.rd_tail ? tail : key_r;
  assign p_idx     = prev_q[IDX_W-1:0];
  assign n_idx     = next_q[IDX_W-1:0];
  assign in_key_ok = int'(req_key) < KEY_SPACE;

  always_comb begin
    status.in_key_ok  = in_key_ok;
    status.kind       = kind_r;
    status.found      = valid_q;
    status.skip_move  = empty || (key_r == head) || prev_q[IDX_W];
    status.list_empty = empty;
    status.over       = 32'(count) > 32'(capacity);
    status.out_free   = !rsp_valid || rsp_ready;
    status.clr_last   = clr_idx == IDX_W'(KEY_SPACE - 1);
  end

  // memory write ports
  always_comb begin
    vld_we   = 1'b0;
    vld_addr = key_r;
    vld_data = 1'b0;
    val_we   = 1'b0;
    val_addr = key_r;
    prv_we   = 1'b0;
    prv_addr = key_r;
    prv_data = '0;
    nxt_we   = 1'b0;
    nxt_addr = key_r;
    nxt_data = '0;
    case (cmd.step)
      STEP_CLR: begin
        vld_we   = 1'b1;
        vld_addr = clr_idx;
      end
      STEP_HIT: begin
        val_we = valid_q && (kind_r == KIND_PUT);
      end
      STEP_INS: begin
        vld_we   = 1'b1;
        vld_data = 1'b1;
        val_we   = 1'b1;
        prv_we   = 1'b1;
        prv_data = {1'b1, {IDX_W{1'b0}}};
        nxt_we   = 1'b1;
        nxt_data = empty ? {1'b1, {IDX_W{1'b0}}} : {1'b0, head};
      end
      STEP_MV1: begin
        nxt_we   = 1'b1;
        nxt_addr = p_idx;
        nxt_data = next_q;
        prv_we   = !next_q[IDX_W];
        prv_addr = n_idx;
        prv_data = {1'b0, p_idx};
      end
      STEP_MV2: begin
        nxt_we   = 1'b1;
        nxt_data = {1'b0, head};
        prv_we   = 1'b1;
        prv_data = {1'b1, {IDX_W{1'b0}}};
      end
      STEP_LINK: begin
        prv_we   = 1'b1;
        prv_addr = head;
        prv_data = {1'b0, key_r};
      end
      STEP_EVICT: begin
        vld_we   = 1'b1;
        vld_addr = tail;
        nxt_we   = !prev_q[IDX_W];
        nxt_addr = p_idx;
        nxt_data = {1'b1, {IDX_W{1'b0}}};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vld_we) valid_mem[vld_addr] <= vld_data;
    if (val_we) value_mem[val_addr] <= val_r;
    if (prv_we) prev_mem[prv_addr] <= prv_data;
    if (nxt_we) next_mem[nxt_addr] <= nxt_data;
    if (cmd.rd_en) begin
      valid_q <= valid_mem[rd_addr];
      value_q <= value_mem[rd_addr];
      prev_q  <= prev_mem[rd_addr];
      next_q  <= next_mem[rd_addr];
    end
  end

  // list pointers, count, config, output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      count     <= '0;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write_en) capacity <= cfg_write_data;
      case (cmd.step)
        STEP_CLR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        STEP_INS: begin
          count <= count + 1'b1;
          if (empty) begin
            head  <= key_r;
            tail  <= key_r;
            empty <= 1'b0;
          end
        end
        STEP_MV1: begin
          if (key_r == tail) tail <= p_idx;
        end
        STEP_LINK: begin
          head <= key_r;
        end
        STEP_EVICT: begin
          if (prev_q[IDX_W]) begin
            empty <= 1'b1;
            head  <= '0;
            tail  <= '0;
          end else begin
            tail <= p_idx;
          end
          if (count != '0) count <= count - 1'b1;
        end
        default: begin
        end
      endcase
      if (cmd.ld_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request latch and result
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      kind_r       <= req_kind;
      key_r        <= IDX_W'(req_key);
      val_r        <= req_value;
      res_accepted <= in_key_ok;
      res_found    <= 1'b0;
      res_rv       <= (req_kind == KIND_PUT) ? '0 : '1;
      res_ev       <= 1'b0;
      res_evk      <= '0;
    end
    if (cmd.step == STEP_HIT) begin
      res_found <= valid_q;
      if (valid_q && kind_r == KIND_GET) res_rv <= value_q;
    end
    if (cmd.step == STEP_EVICT) begin
      res_ev  <= 1'b1;
      res_evk <= EVK_W'(tail);
    end
    if (cmd.ld_out) begin
      accepted    <= res_accepted;
      found       <= res_found;
      read_value  <= res_rv;
      evicted     <= res_ev;
      evicted_key <= res_evk;
    end
  end

endmodule

[design/lkv_checker.sv]
// ---------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU cache, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lkv_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        accepted,
  input logic        found,
  input logic [31:0] read_value,
  input logic        evicted,
  input logic [6:0]  evicted_key
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value), "response word changed while stalled")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready, "second word taken before the first finished")
  `ASSERT_IMPL(a_reject_clean, clk, rst, rsp_valid && !accepted, !found && !evicted && evicted_key == 7'd0, "rejected key reported a hit or an eviction")
  `ASSERT_IMPL(a_evk_zero, clk, rst, rsp_valid && !evicted, evicted_key == 7'd0, "eviction key set without an eviction")
  `ASSERT_IMPL(a_hit_no_evict, clk, rst, rsp_valid && found, !evicted, "hit reported an eviction")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .accepted    (rsp.accepted),
  .found       (rsp.found),
  .read_value  (rsp.read_value),
  .evicted     (rsp.evicted),
  .evicted_key (rsp.evicted_key)
);

[tb/lru_key_value_cache_checker.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the request, response and capacity ports of the LRU cache. It keeps
// its own copy of the slot table and the recency chain, works out the reply
// of every accepted request word, and compares each response word in order.
// ---------------------------------------------------------------------------
module lru_key_value_cache_checker import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [CAP_W-1:0] cfg_write_data,
  lkv_req_if               req,
  lkv_rsp_if               rsp,
  output int               mismatch_count,
  output int               words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = KEY_SPACE_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef logic [EVK_W-1:0] slot_t;

  typedef struct packed {
    logic             accepted;
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [EVK_W-1:0] evicted_key;
  } cache_reply_t;

  logic             entry_live  [SLOTS];
  logic [VAL_W-1:0] entry_value [SLOTS];
  slot_t            link_newer  [SLOTS];
  slot_t            link_older  [SLOTS];
  logic             newer_none  [SLOTS];
  logic             older_none  [SLOTS];
  slot_t            mru_slot;
  slot_t            lru_slot;
  logic             chain_empty;
  int               live_count;
  int               cap_limit;
  cache_reply_t     replies_due [$];

  function automatic void link_at_front(input slot_t s);
    newer_none[s] = 1'b1;
    if (chain_empty) begin
      older_none[s] = 1'b1;
      link_older[s] = '0;
      lru_slot = s;
      chain_empty = 1'b0;
    end else begin
      older_none[s] = 1'b0;
      link_older[s] = mru_slot;
      link_newer[mru_slot] = s;
      newer_none[mru_slot] = 1'b0;
    end
    link_newer[s] = '0;
    mru_slot = s;
  endfunction

  function automatic void bring_forward(input slot_t s);
    slot_t p;
    slot_t n;
    if (chain_empty || s == mru_slot || newer_none[s]) return;
    p = link_newer[s];
    n = link_older[s];
    link_older[p] = n;
    older_none[p] = older_none[s];
    if (!older_none[s]) begin
      link_newer[n] = p;
      newer_none[n] = 1'b0;
    end
    if (s == lru_slot) lru_slot = p;
    link_at_front(s);
  endfunction

  function automatic logic drop_lru(output slot_t victim);
    slot_t t;
    slot_t p;
    victim = '0;
    if (chain_empty) return 1'b0;
    t = lru_slot;
    if (newer_none[t]) begin
      chain_empty = 1'b1;
      mru_slot = '0;
      lru_slot = '0;
    end else begin
      p = link_newer[t];
      older_none[p] = 1'b1;
      link_older[p] = '0;
      lru_slot = p;
    end
    entry_live[t] = 1'b0;
    if (live_count > 0) live_count--;
    victim = t;
    return 1'b1;
  endfunction

  function automatic cache_reply_t cache_access(input logic kind, input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] value);
    cache_reply_t r;
    slot_t        s;
    slot_t        victim;
    r = '0;
    if (key < SLOTS) begin
      s = key[EVK_W-1:0];
      r.accepted = 1'b1;
      r.found = entry_live[s];
      if (kind == KIND_GET) begin
        if (r.found) begin
          bring_forward(s);
          r.read_value = entry_value[s];
        end else begin
          r.read_value = '1;
        end
      end else if (r.found) begin
        entry_value[s] = value;
        bring_forward(s);
      end else begin
        entry_live[s] = 1'b1;
        entry_value[s] = value;
        link_at_front(s);
        live_count++;
        if (live_count > cap_limit && drop_lru(victim)) begin
          r.evicted = 1'b1;
          r.evicted_key = victim;
        end
      end
    end else if (kind == KIND_GET) begin
      r.read_value = '1;
    end
    return r;
  endfunction

  function automatic string describe(input cache_reply_t r);
    return $sformatf("acc=%0d found=%0d value=%0d evicted=%0d key=%0d", r.accepted, r.found,
                     $signed(r.read_value), r.evicted, r.evicted_key);
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("cache reply error at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cache_reply_t due;
    cache_reply_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        entry_live[i] = 1'b0;
        entry_value[i] = '0;
        link_newer[i] = '0;
        link_older[i] = '0;
        newer_none[i] = 1'b0;
        older_none[i] = 1'b0;
      end
      mru_slot = '0;
      lru_slot = '0;
      chain_empty = 1'b1;
      live_count = 0;
      cap_limit = int'(CAP_RESET);
      replies_due.delete();
    end else begin
      if (cfg_write_en) cap_limit = int'(cfg_write_data);
      if (rsp.valid && rsp.ready) begin
        got = {rsp.accepted, rsp.found, rsp.read_value, rsp.evicted, rsp.evicted_key};
        if (replies_due.size() == 0) begin
          flag_error($sformatf("reply with none outstanding: %s", describe(got)));
        end else begin
          due = replies_due.pop_front();
          if (got.accepted !== due.accepted || got.found !== due.found ||
              got.read_value !== due.read_value || got.evicted !== due.evicted ||
              got.evicted_key !== due.evicted_key)
            flag_error($sformatf("expected %s, got %s", describe(due), describe(got)));
        end
      end
      if (req.valid && req.ready) replies_due.push_back(cache_access(req.kind, req.key, req.value));
    end
    words_pending <= replies_due.size();
  end

endmodule

[tb/lru_key_value_cache_tb.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives the LRU cache with directed gets and puts (empty cache, misses,
// hits at the front and at the tail, updates, evictions, out-of-range keys,
// zero capacity on an empty cache) and then random bursts at several
// capacities and idle mixes, including a long response stall. The checker
// beside the block predicts and compares every response word.
// ---------------------------------------------------------------------------
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int BURST_WORDS   = 120;

  logic             clk;
  logic             rst;
  logic             cfg_write_en;
  logic [CAP_W-1:0] cfg_write_data;
  int               mismatch_count;
  int               words_pending;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               stall_left;
  int               capacity_now;
  int               cycle_count;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req_ch),
    .rsp            (rsp_ch)
  );

  lru_key_value_cache_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    if (rst !== 1'b0) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic offer_word(input logic kind, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.key <= key;
    req_ch.value <= value;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic quiesce();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    quiesce();
    cfg_write_en <= 1'b1;
    cfg_write_data <= cap;
    capacity_now = cap;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic random_burst(input int words, input bit with_hold);
    int               hot_span;
    int               pick;
    logic [KEY_W-1:0] key;
    hot_span = (capacity_now >= 60) ? 127 : capacity_now * 2 + 3;
    for (int i = 0; i < words; i++) begin
      if (with_hold && i == words / 4) stall_left = LONG_HOLD;
      pick = $urandom_range(99);
      if (pick < 10) key = KEY_W'($urandom_range(255, 128));
      else if (pick < 30) key = KEY_W'($urandom_range(127));
      else key = KEY_W'($urandom_range(hot_span));
      offer_word(1'($urandom_range(1)), key, $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_GET;
    req_ch.key = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    capacity_now = int'(CAP_RESET);
    send_idle_pct = 23;
    recv_idle_pct = 49;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    offer_word(KIND_GET, 8'd0, 32'd0);
    offer_word(KIND_GET, 8'd255, 32'd0);
    offer_word(KIND_PUT, 8'd128, 32'd5);

    // zero capacity on an empty cache: each new key goes straight out again
    write_capacity(8'd0);
    offer_word(KIND_PUT, 8'd0, 32'h7FFF_FFFF);
    offer_word(KIND_PUT, 8'd127, 32'h8000_0000);
    offer_word(KIND_GET, 8'd127, 32'd0);

    write_capacity(8'd2);
    offer_word(KIND_PUT, 8'd0, 32'h7FFF_FFFF);
    offer_word(KIND_PUT, 8'd127, 32'h8000_0000);
    offer_word(KIND_GET, 8'd0, 32'd0);
    offer_word(KIND_PUT, 8'd5, 32'hFFFF_FFFF);
    offer_word(KIND_GET, 8'd127, 32'd0);
    offer_word(KIND_PUT, 8'd0, 32'd0);
    offer_word(KIND_GET, 8'd5, 32'd0);
    offer_word(KIND_GET, 8'd5, 32'd0);
    offer_word(KIND_PUT, 8'd1, 32'h1234_5678);
    offer_word(KIND_GET, 8'd200, 32'hFFFF_FFFF);
    offer_word(KIND_PUT, 8'd255, 32'hFFFF_FFFF);
    offer_word(KIND_GET, 8'd1, 32'd0);
    offer_word(KIND_PUT, 8'd5, 32'h55AA_55AA);
    offer_word(KIND_GET, 8'd128, 32'd0);

    random_burst(BURST_WORDS, 1'b0);
    write_capacity(8'd1);
    random_burst(BURST_WORDS, 1'b0);

    send_idle_pct = 49;
    recv_idle_pct = 23;
    write_capacity(8'd128);
    random_burst(BURST_WORDS, 1'b0);
    write_capacity(8'd0);
    random_burst(BURST_WORDS, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(8'd255);
    random_burst(BURST_WORDS, 1'b1);
    write_capacity(CAP_W'($urandom_range(16, 3)));
    random_burst(BURST_WORDS + 10, 1'b0);

    quiesce();
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
